@@ rtl/gef_pkg.sv @@
// gef_pkg: shared types, constants and helpers of the gradient energy focus tracker
// no dependencies
`default_nettype none

package gef_pkg;

    localparam int SIZE_W     = 13;
    localparam int AREA_W     = 2 * SIZE_W;
    localparam int PIX_W      = 8;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int TERM_W     = SQ_W + 2;
    localparam int METRIC_W   = 25;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_SEL    = 2;

    localparam int COEF_W     = 14;
    localparam int GRAY_SUM_W = 23;
    localparam int GRAY_SHIFT = 14;

    localparam logic [COEF_W-1:0]     COEF_B     = 14'd1868;
    localparam logic [COEF_W-1:0]     COEF_G     = 14'd9617;
    localparam logic [COEF_W-1:0]     COEF_R     = 14'd4899;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 23'd8192;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [SIZE_W-1:0] SIZE_MIN     = 13'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [AREA_W-1:0] area;
        logic              restart;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] r);
        logic [GRAY_SUM_W-1:0] acc;
        acc = GRAY_SUM_W'(COEF_B) * GRAY_SUM_W'(b)
            + GRAY_SUM_W'(COEF_G) * GRAY_SUM_W'(g)
            + GRAY_SUM_W'(COEF_R) * GRAY_SUM_W'(r)
            + GRAY_ROUND;
        return acc[GRAY_SHIFT +: PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

@@ rtl/gef_focus_top.sv @@
// gradient_energy_focus_tracker: gray conversion, gradient energy sum over a frame,
// mean metric by division and min/max tracking
// depends on gef_pkg, gef_cfg, gef_line_buf, gef_div
//
//   channel  direction  handshake          payload
//   request  in         i_valid / o_stall  i_kind, i_blue, i_green, i_red
//   result   out        o_valid / i_stall  o_frame_metric, o_tracked_min, o_tracked_max,
//                                          o_tracked_current, o_initialised_now
//   config   in         apb psel/penable   paddr, pwdata, prdata
//
// one request per cycle while o_stall is low, through a three stage pipeline built around
// the line memory (read in stage one, read-modify-write against the stored row in stage two)
// the last pixel of a frame starts the divider; o_stall stays high while it runs and until
// the result register takes the quotient
// the result register is separate, so requests keep flowing while a result waits
// reset is synchronous and active low; a register write restarts the frame
`default_nettype none

module gradient_energy_focus_tracker import gef_pkg::*; #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [PIX_W-1:0]    i_blue,
    input  logic [PIX_W-1:0]    i_green,
    input  logic [PIX_W-1:0]    i_red,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [METRIC_W-1:0] o_frame_metric,
    output logic [METRIC_W-1:0] o_tracked_min,
    output logic [METRIC_W-1:0] o_tracked_max,
    output logic [METRIC_W-1:0] o_tracked_current,
    output logic                o_initialised_now
);

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int SUM_W   = XW + YW + TERM_W;
    localparam int DIV_RAW = SUM_W + FRACTION_BITS;
    localparam int DIV_W   = (DIV_RAW > METRIC_W) ? DIV_RAW : METRIC_W + 1;

    t_cfg                cfg;
    t_div_status         div_st;
    logic [METRIC_W-1:0] div_q;

    logic                adv;
    logic                in_acc;
    logic                col_last;
    logic                row_last;
    logic                div_start;
    logic                take;

    logic [XW-1:0]       r_col;
    logic [YW-1:0]       r_row;

    // stage a
    logic                r_a_valid;
    logic                r_a_kind;
    logic [PIX_W-1:0]    r_a_b;
    logic [PIX_W-1:0]    r_a_g;
    logic [PIX_W-1:0]    r_a_r;
    logic [XW-1:0]       r_a_x;
    logic                r_a_c0;
    logic                r_a_c1;
    logic                r_a_r0;
    logic                r_a_r1;
    logic                r_a_last;

    // stage b
    logic                r_b_valid;
    logic                r_b_kind;
    logic [PIX_W-1:0]    r_b_gray;
    logic [XW-1:0]       r_b_x;
    logic                r_b_c0;
    logic                r_b_c1;
    logic                r_b_r0;
    logic                r_b_r1;
    logic                r_b_last;
    logic [PIX_W-1:0]    above;
    logic [PIX_W-1:0]    r_left;
    logic [PIX_W-1:0]    d_left;
    logic [PIX_W-1:0]    d_up;
    logic                b_write;

    // stage c
    logic                r_c_valid;
    logic                r_c_kind;
    logic [SQ_W-1:0]     r_c_sq_l;
    logic [SQ_W-1:0]     r_c_sq_u;
    logic                r_c_c0;
    logic                r_c_c1;
    logic                r_c_r0;
    logic                r_c_r1;
    logic                r_c_last;
    logic [TERM_W-1:0]   t_left;
    logic [TERM_W-1:0]   t_up;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    r_sum;

    // tracking and result
    logic [METRIC_W-1:0] r_min;
    logic [METRIC_W-1:0] r_max;
    logic [METRIC_W-1:0] r_cur;
    logic [METRIC_W-1:0] n_min;
    logic [METRIC_W-1:0] n_max;
    logic [METRIC_W-1:0] n_cur;
    logic                n_init;
    logic                r_o_valid;
    logic [METRIC_W-1:0] r_o_metric;
    logic [METRIC_W-1:0] r_o_min;
    logic [METRIC_W-1:0] r_o_max;
    logic [METRIC_W-1:0] r_o_cur;
    logic                r_o_init;

    gef_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv     = !(div_st.busy || div_st.done);
    assign o_stall = !adv;
    assign in_acc  = i_valid && adv;

    assign col_last = ({1'b0, SIZE_W'(r_col)} + 1'b1) == {1'b0, cfg.width};
    assign row_last = ({1'b0, SIZE_W'(r_row)} + 1'b1) == {1'b0, cfg.height};

    // frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc && i_kind == KIND_PIXEL) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage a: capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_kind <= i_kind;
            r_a_b    <= i_blue;
            r_a_g    <= i_green;
            r_a_r    <= i_red;
            r_a_x    <= r_col;
            r_a_c0   <= r_col == '0;
            r_a_c1   <= r_col == XW'(1);
            r_a_r0   <= r_row == '0;
            r_a_r1   <= r_row == YW'(1);
            r_a_last <= col_last && row_last;
        end
    end

    gef_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (XW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (adv && r_a_valid),
        .i_rd_addr (r_a_x),
        .o_rd_data (above),
        .i_wr_en   (b_write),
        .i_wr_addr (r_b_x),
        .i_wr_data (r_b_gray)
    );

    // stage b: gray and row above available
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_a_valid) begin
            r_b_kind <= r_a_kind;
            r_b_gray <= gray_of(r_a_b, r_a_g, r_a_r);
            r_b_x    <= r_a_x;
            r_b_c0   <= r_a_c0;
            r_b_c1   <= r_a_c1;
            r_b_r0   <= r_a_r0;
            r_b_r1   <= r_a_r1;
            r_b_last <= r_a_last;
        end
    end

    assign b_write = adv && r_b_valid && r_b_kind == KIND_PIXEL;
    assign d_left  = abs_diff(r_b_gray, r_left);
    assign d_up    = abs_diff(r_b_gray, above);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg.restart) begin
            r_left <= '0;
        end else if (b_write) begin
            r_left <= r_b_gray;
        end
    end

    // stage c: weighted terms and frame sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid) begin
            r_c_kind <= r_b_kind;
            r_c_sq_l <= SQ_W'(d_left) * SQ_W'(d_left);
            r_c_sq_u <= SQ_W'(d_up) * SQ_W'(d_up);
            r_c_c0   <= r_b_c0;
            r_c_c1   <= r_b_c1;
            r_c_r0   <= r_b_r0;
            r_c_r1   <= r_b_r1;
            r_c_last <= r_b_last;
        end
    end

    // reflect-101 border: first column/row adds nothing, second counts twice
    always_comb begin
        if (r_c_c0) begin
            t_left = '0;
        end else if (r_c_c1) begin
            t_left = TERM_W'(r_c_sq_l) << 1;
        end else begin
            t_left = TERM_W'(r_c_sq_l);
        end
        if (r_c_r0) begin
            t_up = '0;
        end else if (r_c_r1) begin
            t_up = TERM_W'(r_c_sq_u) << 1;
        end else begin
            t_up = TERM_W'(r_c_sq_u);
        end
    end

    assign sum_next  = r_sum + SUM_W'(t_left) + SUM_W'(t_up);
    assign div_start = adv && r_c_valid && r_c_kind == KIND_PIXEL && r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg.restart) begin
            r_sum <= '0;
        end else if (adv && r_c_valid && r_c_kind == KIND_PIXEL) begin
            r_sum <= r_c_last ? '0 : sum_next;
        end
    end

    gef_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIV_W'(sum_next) << FRACTION_BITS),
        .i_divisor  (cfg.area),
        .i_take     (take),
        .o_status   (div_st),
        .o_quotient (div_q)
    );

    // tracking update
    assign take   = div_st.done && (!r_o_valid || !i_stall);
    assign n_init = (r_min == '0) && (r_max == '0);

    always_comb begin
        if (n_init) begin
            n_min = div_q;
            n_max = div_q;
            n_cur = r_cur;
        end else begin
            n_min = (div_q < r_min) ? div_q : r_min;
            n_max = (div_q > r_max) ? div_q : r_max;
            n_cur = div_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
            r_cur <= '0;
        end else if (take) begin
            r_min <= n_min;
            r_max <= n_max;
            r_cur <= n_cur;
        end else if (adv && r_c_valid && r_c_kind == KIND_CLEAR) begin
            r_min <= '0;
            r_max <= '0;
            r_cur <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_metric <= div_q;
            r_o_min    <= n_min;
            r_o_max    <= n_max;
            r_o_cur    <= n_cur;
            r_o_init   <= n_init;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_frame_metric    = r_o_metric;
    assign o_tracked_min     = r_o_min;
    assign o_tracked_max     = r_o_max;
    assign o_tracked_current = r_o_cur;
    assign o_initialised_now = r_o_init;

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("tracked min above tracked max");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W'(r_col) < cfg.width) && (SIZE_W'(r_row) < cfg.height))
        else $error("frame position outside configured size");

    a_result_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(div_st.done))
        else $error("result raised without a finished division");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg.restart |=> (r_col == '0) && (r_row == '0) && (r_sum == '0))
        else $error("register write did not restart the frame");

endmodule

`default_nettype wire

@@ rtl/gef_cfg.sv @@
// gef_cfg: apb register bank for frame width and height, with the frame area product
// depends on gef_pkg
`default_nettype none

module gef_cfg import gef_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    localparam logic [SIZE_W:0] WIDTH_HI  = (SIZE_W+1)'(MAX_WIDTH);
    localparam logic [SIZE_W:0] HEIGHT_HI = (SIZE_W+1)'(MAX_HEIGHT);

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [AREA_W-1:0] r_area;
    logic              wr;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W:0]   hi);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if ({1'b0, v} > hi) begin
            res = hi[SIZE_W-1:0];
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (wr) begin
            if (paddr[REG_SEL] == REG_HEIGHT) begin
                r_height <= clamp_size(pwdata[SIZE_W-1:0], HEIGHT_HI);
            end else begin
                r_width <= clamp_size(pwdata[SIZE_W-1:0], WIDTH_HI);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(r_width) * AREA_W'(r_height);
    end

    always_comb begin
        if (paddr[REG_SEL] == REG_HEIGHT) begin
            prdata = PDATA_W'(r_height);
        end else begin
            prdata = PDATA_W'(r_width);
        end
    end

    assign o_cfg.width   = r_width;
    assign o_cfg.height  = r_height;
    assign o_cfg.area    = r_area;
    assign o_cfg.restart = wr;

endmodule

`default_nettype wire

@@ rtl/gef_line_buf.sv @@
// gef_line_buf: one-row gray line memory, one write and one registered read port
// depends on gef_pkg
`default_nettype none

module gef_line_buf import gef_pkg::*; #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [PIX_W-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]  i_wr_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/gef_div.sv @@
// gef_div: restoring divider, one quotient bit per cycle, saturating metric result
// depends on gef_pkg
`default_nettype none

module gef_div import gef_pkg::*; #(
    parameter int DIV_W = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [AREA_W-1:0]   i_divisor,
    input  logic                i_take,
    output t_div_status         o_status,
    output logic [METRIC_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_quo;
    logic [AREA_W:0]   r_rem;
    logic [AREA_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [AREA_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {r_rem[AREA_W-1:0], r_quo[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = (|r_quo[DIV_W-1:METRIC_W]) ? {METRIC_W{1'b1}}
                                                      : r_quo[METRIC_W-1:0];

endmodule

`default_nettype wire
